// File: hw/rtl/moca_pkg.sv
`default_nettype none

package moca_pkg;

  localparam int unsigned MaskW      = 8;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned TableW     = 64;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned DivInW     = 4;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 16;

  typedef enum logic [CfgIndexW-1:0] {
    CfgMaskCount  = 2'd0,
    CfgRedTable   = 2'd1,
    CfgGreenTable = 2'd2,
    CfgBlueTable  = 2'd3
  } cfg_reg_e;

  // One classified pixel: the enabled masks that cover it and its end marker.
  typedef struct packed {
    logic [MaskW-1:0] hits;
    logic             last;
  } entry_t;

  // Rounded-up reciprocal of the covering count, scaled by 2^RecipShift.
  // With sums below 2^11 the scaled product truncates to the exact quotient.
  // A count of zero maps to zero so that an uncovered pixel yields zero.
  function automatic logic [RecipW-1:0] recip(input logic [DivInW-1:0] d);
    logic [RecipW-1:0] r;
    unique case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/moca_front.sv
`default_nettype none

module moca_front #(
  parameter int unsigned MASKS = 8
) (
  input  wire logic [moca_pkg::MaskW-1:0]  mask_bits_i,
  input  wire logic                        end_of_image_i,
  input  wire logic [moca_pkg::CountW-1:0] mask_count_i,
  output moca_pkg::entry_t                 entry_o
);

  // A mask takes part only if it exists in this build and lies below the count.
  always_comb begin
    entry_o.hits = '0;
    entry_o.last = end_of_image_i;
    for (int m = 0; m < int'(moca_pkg::MaskW); m++) begin
      if (m < int'(MASKS)) begin
        entry_o.hits[m] = mask_bits_i[m] && (moca_pkg::CountW'(m) < mask_count_i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/moca_fifo.sv
`default_nettype none

module moca_fifo #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/moca_back.sv
`default_nettype none

module moca_back #(
  parameter int unsigned MASKS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire moca_pkg::entry_t            entry_i,
  output logic                             ready_o,
  input  wire logic [moca_pkg::TableW-1:0] red_table_i,
  input  wire logic [moca_pkg::TableW-1:0] green_table_i,
  input  wire logic [moca_pkg::TableW-1:0] blue_table_i,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [moca_pkg::ColorW-1:0]      red_o,
  output logic [moca_pkg::ColorW-1:0]      green_o,
  output logic [moca_pkg::ColorW-1:0]      blue_o,
  output logic                             covered_o,
  output logic                             last_pixel_o
);

  localparam int unsigned SumW  = $clog2(255 * MASKS + 1);
  localparam int unsigned CntW  = $clog2(MASKS + 1);
  localparam int unsigned ProdW = SumW + moca_pkg::RecipW;

  // Stage A: channel sums and covering count.
  logic            a_valid_q;
  logic [SumW-1:0] a_red_q, a_green_q, a_blue_q;
  logic [CntW-1:0] a_hits_q;
  logic            a_last_q;

  // Stage B: the output register.
  logic            b_valid_q;

  logic            ready_a, ready_b;
  logic [SumW-1:0] sum_r, sum_g, sum_b;
  logic [CntW-1:0] hit_cnt;

  logic [moca_pkg::RecipW-1:0] rcp;
  logic [ProdW-1:0]            prod_r, prod_g, prod_b;

  assign ready_b = !b_valid_q || pop;
  assign ready_a = !a_valid_q || ready_b;
  assign ready_o = ready_a;
  assign empty   = !b_valid_q;

  always_comb begin
    sum_r   = '0;
    sum_g   = '0;
    sum_b   = '0;
    hit_cnt = '0;
    for (int m = 0; m < int'(MASKS); m++) begin
      if (entry_i.hits[m]) begin
        sum_r   = sum_r + SumW'(red_table_i[8*m +: 8]);
        sum_g   = sum_g + SumW'(green_table_i[8*m +: 8]);
        sum_b   = sum_b + SumW'(blue_table_i[8*m +: 8]);
        hit_cnt = hit_cnt + CntW'(1);
      end
    end
  end

  assign rcp    = moca_pkg::recip(moca_pkg::DivInW'(a_hits_q));
  assign prod_r = a_red_q * rcp;
  assign prod_g = a_green_q * rcp;
  assign prod_b = a_blue_q * rcp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_q <= valid_i;
      end
      if (ready_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_a) begin
      a_red_q   <= sum_r;
      a_green_q <= sum_g;
      a_blue_q  <= sum_b;
      a_hits_q  <= hit_cnt;
      a_last_q  <= entry_i.last;
    end
    if (a_valid_q && ready_b) begin
      red_o        <= prod_r[moca_pkg::RecipShift +: moca_pkg::ColorW];
      green_o      <= prod_g[moca_pkg::RecipShift +: moca_pkg::ColorW];
      blue_o       <= prod_b[moca_pkg::RecipShift +: moca_pkg::ColorW];
      covered_o    <= (a_hits_q != '0);
      last_pixel_o <= a_last_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mask_overlap_color_average.sv
`default_nettype none

// Blends the colors of up to MASKS label masks over one pixel: every enabled
// mask that covers the pixel contributes its RGB color and the result is the
// truncated per-channel average, with covered low and a zero color when no
// enabled mask covers it. One pixel is taken every clock for as long as the
// result side keeps popping; a pixel's result reaches the result ports through
// the queue entry, then the sum stage, then the reciprocal multiply stage. A
// two-entry queue between the classify front and the arithmetic back absorbs
// a stall of the result side before full rises. Configuration writes are
// always ready and take effect on the next clock; the user must make them
// while no pixel is in flight, and the block itself does not enforce this.
module mask_overlap_color_average #(
  parameter int unsigned MASKS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [moca_pkg::MaskW-1:0]     mask_bits_i,
  input  wire logic                           end_of_image_i,
  input  wire logic                           pop,
  output logic                                empty,
  output logic [moca_pkg::ColorW-1:0]         red_o,
  output logic [moca_pkg::ColorW-1:0]         green_o,
  output logic [moca_pkg::ColorW-1:0]         blue_o,
  output logic                                covered_o,
  output logic                                last_pixel_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [moca_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [moca_pkg::TableW-1:0]    cfg_data_i
);

  localparam int unsigned EntryW = $bits(moca_pkg::entry_t);

  logic [moca_pkg::CountW-1:0] mask_count_q;
  logic [moca_pkg::TableW-1:0] red_table_q, green_table_q, blue_table_q;

  moca_pkg::entry_t front_entry, back_entry;
  logic [EntryW-1:0] back_bits;
  logic              q_empty, back_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_count_q  <= '0;
      red_table_q   <= '0;
      green_table_q <= '0;
      blue_table_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (moca_pkg::cfg_reg_e'(cfg_index_i))
        moca_pkg::CfgMaskCount:  mask_count_q  <= cfg_data_i[moca_pkg::CountW-1:0];
        moca_pkg::CfgRedTable:   red_table_q   <= cfg_data_i;
        moca_pkg::CfgGreenTable: green_table_q <= cfg_data_i;
        moca_pkg::CfgBlueTable:  blue_table_q  <= cfg_data_i;
      endcase
    end
  end

  moca_front #(
    .MASKS(MASKS)
  ) u_front (
    .mask_bits_i   (mask_bits_i),
    .end_of_image_i(end_of_image_i),
    .mask_count_i  (mask_count_q),
    .entry_o       (front_entry)
  );

  moca_fifo #(
    .Width(EntryW),
    .Depth(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_entry),
    .full_o (full),
    .pop_i  (back_ready),
    .data_o (back_bits),
    .empty_o(q_empty)
  );

  assign back_entry = moca_pkg::entry_t'(back_bits);

  moca_back #(
    .MASKS(MASKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (!q_empty),
    .entry_i      (back_entry),
    .ready_o      (back_ready),
    .red_table_i  (red_table_q),
    .green_table_i(green_table_q),
    .blue_table_i (blue_table_q),
    .pop          (pop),
    .empty        (empty),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .covered_o    (covered_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/moca_checker.sv
`default_nettype none

module moca_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        full,
  input wire logic                        pop,
  input wire logic                        empty,
  input wire logic [moca_pkg::ColorW-1:0] red_o,
  input wire logic [moca_pkg::ColorW-1:0] green_o,
  input wire logic [moca_pkg::ColorW-1:0] blue_o,
  input wire logic                        covered_o,
  input wire logic                        last_pixel_o
);

  // A waiting result must not vanish before it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without a pop");

  // A waiting result holds its value until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(red_o) && $stable(green_o) && $stable(blue_o)
                          && $stable(covered_o) && $stable(last_pixel_o)))
    else $error("result changed while stalled");

  // An uncovered pixel carries a zero color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !covered_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("uncovered pixel with nonzero color");

  // The input queue fills only behind a result that is being held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> !empty)
    else $error("input side full while no result waits");

endmodule

bind mask_overlap_color_average moca_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/moca_color_checker.sv
`default_nettype none

// Watches the pixel, result and register channels of the blender. It keeps its
// own copy of the registers, works out the color of every accepted pixel and
// compares each popped result with the oldest color still owed.
module moca_color_checker
  import moca_pkg::*;
#(
  parameter int unsigned MASKS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic                 full_i,
  input  wire logic [MaskW-1:0]     mask_bits_i,
  input  wire logic                 end_of_image_i,
  input  wire logic                 pop_i,
  input  wire logic                 empty_i,
  input  wire logic [ColorW-1:0]    red_i,
  input  wire logic [ColorW-1:0]    green_i,
  input  wire logic [ColorW-1:0]    blue_i,
  input  wire logic                 covered_i,
  input  wire logic                 last_pixel_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [TableW-1:0]    cfg_data_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               pixels_o,
  output int unsigned               checked_o,
  output int unsigned               covered_o,
  output int unsigned               cfg_writes_o
);

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              covered;
    logic              last;
  } pixel_color_t;

  logic [CountW-1:0] mask_count_q = '0;
  logic [TableW-1:0] red_table_q = '0;
  logic [TableW-1:0] green_table_q = '0;
  logic [TableW-1:0] blue_table_q = '0;

  pixel_color_t owed_colors[$];

  int unsigned fail_count = 0;
  int unsigned pending = 0;
  int unsigned pixels = 0;
  int unsigned checked = 0;
  int unsigned covered_count = 0;
  int unsigned cfg_writes = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign pixels_o     = pixels;
  assign checked_o    = checked;
  assign covered_o    = covered_count;
  assign cfg_writes_o = cfg_writes;

  // Average of the colors of the enabled masks that cover the pixel. A count
  // above the number of masks enables all of them.
  function automatic pixel_color_t blend_colors(input logic [MaskW-1:0] bits,
                                                input logic eoi);
    int unsigned limit;
    int unsigned hits;
    int unsigned sum_r;
    int unsigned sum_g;
    int unsigned sum_b;
    pixel_color_t c;
    limit = (mask_count_q > MASKS) ? MASKS : int'(mask_count_q);
    hits  = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int unsigned m = 0; m < limit; m++) begin
      if (bits[m]) begin
        sum_r += red_table_q[8*m +: 8];
        sum_g += green_table_q[8*m +: 8];
        sum_b += blue_table_q[8*m +: 8];
        hits++;
      end
    end
    c = '0;
    c.last = eoi;
    if (hits != 0) begin
      c.red     = ColorW'(sum_r / hits);
      c.green   = ColorW'(sum_g / hits);
      c.blue    = ColorW'(sum_b / hits);
      c.covered = 1'b1;
    end
    return c;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch on %s of result %0d: expected %0d, got %0d",
               field, checked, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_color_t want;
    pixel_color_t got;
    if (!rst_ni) begin
      mask_count_q  <= '0;
      red_table_q   <= '0;
      green_table_q <= '0;
      blue_table_q  <= '0;
      owed_colors.delete();
      pending = 0;
    end else begin
      // A pixel taken on the same edge as a mask count write still sees the old
      // count, so the prediction reads the registers before they update.
      if (push_i && !full_i) begin
        owed_colors.push_back(blend_colors(mask_bits_i, end_of_image_i));
        pixels++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        cfg_writes++;
        case (cfg_reg_e'(cfg_index_i))
          CfgMaskCount:  mask_count_q  <= cfg_data_i[CountW-1:0];
          CfgRedTable:   red_table_q   <= cfg_data_i;
          CfgGreenTable: green_table_q <= cfg_data_i;
          CfgBlueTable:  blue_table_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        got = '{red_i, green_i, blue_i, covered_i, last_pixel_i};
        if (owed_colors.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result popped with no pixel waiting: rgb %0d/%0d/%0d",
                     got.red, got.green, got.blue);
          end
        end else begin
          want = owed_colors.pop_front();
          if (got.red !== want.red) flag_field("red", want.red, got.red);
          if (got.green !== want.green) flag_field("green", want.green, got.green);
          if (got.blue !== want.blue) flag_field("blue", want.blue, got.blue);
          if (got.covered !== want.covered) begin
            flag_field("covered", want.covered, got.covered);
          end
          if (got.last !== want.last) flag_field("last_pixel", want.last, got.last);
          if (want.covered) covered_count++;
        end
        checked++;
      end
      pending = owed_colors.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/mask_overlap_color_average_tb.sv
`default_nettype none

module mask_overlap_color_average_tb;
  import moca_pkg::*;

  localparam int unsigned Masks       = 8;
  localparam int unsigned PhasePixels = 50;
  localparam int unsigned Phases      = 9;
  localparam int unsigned IdleLimit   = 250;
  localparam int unsigned DrainCycles = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              pop = 1'b0;
  logic [MaskW-1:0]  mask_bits = '0;
  logic              end_of_image = 1'b0;
  logic              cfg_valid = 1'b0;
  cfg_reg_e          cfg_index = CfgMaskCount;
  logic [TableW-1:0] cfg_data = '0;

  wire logic              full;
  wire logic              empty;
  wire logic [ColorW-1:0] red;
  wire logic [ColorW-1:0] green;
  wire logic [ColorW-1:0] blue;
  wire logic              covered;
  wire logic              last_pixel;
  wire logic              cfg_ready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixels;
  int unsigned checked;
  int unsigned covered_count;
  int unsigned cfg_writes;

  // Set while the pixel side runs without gaps.
  logic steady_in = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mask_overlap_color_average #(
    .MASKS(Masks)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .mask_bits_i   (mask_bits),
    .end_of_image_i(end_of_image),
    .pop           (pop),
    .empty         (empty),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .covered_o     (covered),
    .last_pixel_o  (last_pixel),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  moca_color_checker #(
    .MASKS(Masks)
  ) color_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .mask_bits_i   (mask_bits),
    .end_of_image_i(end_of_image),
    .pop_i         (pop),
    .empty_i       (empty),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .covered_i     (covered),
    .last_pixel_i  (last_pixel),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .pixels_o      (pixels),
    .checked_o     (checked),
    .covered_o     (covered_count),
    .cfg_writes_o  (cfg_writes)
  );

  // All tasks start and end at a falling edge.
  task automatic send_pixel(input logic [MaskW-1:0] bits, input logic eoi);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         = 1'b1;
    mask_bits    = bits;
    end_of_image = eoi;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Stops pushing and waits until every owed color has been popped.
  task automatic settle();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [TableW-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_palette(input logic [CountW-1:0] count,
                              input logic [TableW-1:0] r,
                              input logic [TableW-1:0] g,
                              input logic [TableW-1:0] b);
    write_reg(CfgMaskCount, TableW'(count));
    write_reg(CfgRedTable, r);
    write_reg(CfgGreenTable, g);
    write_reg(CfgBlueTable, b);
  endtask

  function automatic logic [TableW-1:0] random_table();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [MaskW-1:0] random_coverage();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return MaskW'(1) << $urandom_range(0, MaskW - 1);
      default: return MaskW'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: a random stall before each pop, with stretches of
  // back-to-back pops.
  initial begin : result_drain
    int unsigned stall;
    logic fast;
    fast = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) fast = !fast;
      stall = fast ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no request moved for %0d cycles", IdleLimit);
    $display("** mask_overlap_color_average: FAILED **");
    $finish;
  end

  initial begin : pixel_source
    logic [CountW-1:0] count;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Registers still at their reset values: no mask is enabled.
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    settle();

    // All masks enabled, with colors that make the averages truncate.
    load_palette(4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0102_0304_0506_07FE,
                 64'hFF00_FF00_FF00_FF00);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    for (int m = 0; m < MaskW; m++) send_pixel(MaskW'(1) << m, m[0]);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b1);
    settle();

    // A count past the number of masks behaves like the full count.
    write_reg(CfgMaskCount, TableW'(15));
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h80, 1'b0);
    settle();

    // Coverage bits of disabled masks must be ignored.
    write_reg(CfgMaskCount, TableW'(3));
    send_pixel(8'hF8, 1'b0);
    send_pixel(8'h07, 1'b1);
    send_pixel(8'h0C, 1'b0);
    settle();

    write_reg(CfgMaskCount, TableW'(1));
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'h01, 1'b1);
    settle();

    write_reg(CfgMaskCount, TableW'(0));
    send_pixel(8'hFF, 1'b0);
    settle();

    for (int p = 0; p < Phases; p++) begin
      case ($urandom_range(0, 3))
        0:       count = 4'd8;
        1:       count = CountW'($urandom_range(9, 15));
        default: count = CountW'($urandom_range(0, 8));
      endcase
      load_palette(count, random_table(), random_table(), random_table());
      repeat (PhasePixels) begin
        send_pixel(random_coverage(), $urandom_range(0, 7) == 0);
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d pixels under %0d register writes, directed and random.",
             pixels, cfg_writes);
    $display("Checked %0d result colors, %0d of them from covered pixels.",
             checked, covered_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** mask_overlap_color_average: PASSED **");
    end else begin
      $display("** mask_overlap_color_average: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
